// ----- sv/wbc_pkg.sv -----
// wbc_pkg: shared types, constants and fixed-point helpers for the wheel balance block
`timescale 1ns / 1ps
package wbc_pkg;

   // wheel and pair geometry
   localparam int WHEEL_COUNT = 4;
   localparam int WHEEL_W     = $clog2(WHEEL_COUNT);
   localparam int PAIR_COUNT  = WHEEL_COUNT * (WHEEL_COUNT - 1) / 2;
   localparam int PAIR_W      = $clog2(PAIR_COUNT);

   // field widths
   localparam int DIR_W    = 3;
   localparam int CNT_W    = 16;
   localparam int REG_W    = 16;
   localparam int FACTOR_W = 15;
   localparam int SUM_W    = CNT_W + 3;
   localparam int MUL_B_W  = REG_W + 1;
   localparam int PROD_W   = SUM_W + MUL_B_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int FRAC_SH  = 6;
   localparam int PWM_SH   = 14;

   // factor limits in unsigned Q1.14
   localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(16384);
   localparam logic [FACTOR_W-1:0] FACTOR_LO  = FACTOR_W'(4915);
   localparam logic [FACTOR_W-1:0] FACTOR_HI  = FACTOR_W'(29491);

   // configuration registers
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN      = CSR_INDEX_W'(1);
   localparam logic [REG_W-1:0] TOLERANCE_RESET = REG_W'(15);
   localparam logic [REG_W-1:0] GAIN_RESET      = REG_W'(1049);

   typedef logic [WHEEL_W-1:0] wheel_idx_type;
   typedef wheel_idx_type [PAIR_COUNT-1:0] pair_tab_type;

   typedef struct packed {
      logic [DIR_W-1:0]        drive_direction;
      logic signed [CNT_W-1:0] count_a;
      logic signed [CNT_W-1:0] count_b;
      logic signed [CNT_W-1:0] count_c;
      logic signed [CNT_W-1:0] count_d;
      logic signed [CNT_W-1:0] drive_a;
      logic signed [CNT_W-1:0] drive_b;
      logic signed [CNT_W-1:0] drive_c;
      logic signed [CNT_W-1:0] drive_d;
   } req_type;

   typedef struct packed {
      logic signed [CNT_W-1:0] out_a;
      logic signed [CNT_W-1:0] out_b;
      logic signed [CNT_W-1:0] out_c;
      logic signed [CNT_W-1:0] out_d;
      logic [WHEEL_COUNT-1:0]  normal_mask;
   } rsp_type;

   // operands of the shared multiplier
   typedef struct packed {
      logic                      en;
      logic signed [SUM_W-1:0]   op_a;
      logic signed [MUL_B_W-1:0] op_b;
   } mul_req_type;

   // pair table: first or second wheel of each unordered pair
   function automatic pair_tab_type pair_tab(input logic second);
      pair_tab_type tab;
      int           p;
      tab = '0;
      p   = 0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         for (int j = i + 1; j < WHEEL_COUNT; j++) begin
            tab[p] = second ? WHEEL_W'(j) : WHEEL_W'(i);
            p      = p + 1;
         end
      end
      return tab;
   endfunction

   localparam pair_tab_type PAIR_FIRST  = pair_tab(1'b0);
   localparam pair_tab_type PAIR_SECOND = pair_tab(1'b1);

   // 2^20 + gain*s, floored to unsigned Q1.14 and clamped
   function automatic logic [FACTOR_W-1:0] to_factor(input logic signed [PROD_W-1:0] prod);
      logic signed [ACC_W-1:0]        acc;
      logic        [ACC_W-FRAC_SH-1:0] q;
      acc = ACC_W'(prod) + ACC_W'(1 << 20);
      q   = acc[ACC_W-1:FRAC_SH];
      if (acc[ACC_W-1]) begin
         return FACTOR_LO;
      end else if (q < (ACC_W-FRAC_SH)'(FACTOR_LO)) begin
         return FACTOR_LO;
      end else if (q > (ACC_W-FRAC_SH)'(FACTOR_HI)) begin
         return FACTOR_HI;
      end
      return q[FACTOR_W-1:0];
   endfunction

   // drive*factor / 2^14 toward zero, saturated to int16
   function automatic logic signed [CNT_W-1:0] scale_pwm(
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [PROD_W-1:0] biased;
      logic signed [PROD_W-1:0] q;
      biased = prod;
      if (prod[PROD_W-1]) begin
         biased = prod + PROD_W'((1 << PWM_SH) - 1);
      end
      q = biased >>> PWM_SH;
      if (q > $signed(PROD_W'(32767))) begin
         return CNT_W'(32767);
      end else if (q < -$signed(PROD_W'(32768))) begin
         return CNT_W'(32768);
      end
      return q[CNT_W-1:0];
   endfunction

endpackage

// ----- sv/wbc_agree.sv -----
// wbc_agree: shared count comparator, checks one wheel pair against the tolerance
`timescale 1ns / 1ps
module wbc_agree (
   input  logic signed [wbc_pkg::CNT_W-1:0] cnt_x,
   input  logic signed [wbc_pkg::CNT_W-1:0] cnt_y,
   input  logic        [wbc_pkg::REG_W-1:0] tolerance,
   output logic                             agree
);
   import wbc_pkg::*;

   logic signed [CNT_W:0] diff;
   logic        [CNT_W:0] mag;

   // absolute difference against tolerance
   always_comb begin
      diff  = (CNT_W+1)'(cnt_x) - (CNT_W+1)'(cnt_y);
      mag   = diff[CNT_W] ? (CNT_W+1)'(-diff) : diff;
      agree = mag <= {1'b0, tolerance};
   end

endmodule

// ----- sv/wbc_mul.sv -----
// wbc_mul: shared signed multiplier with registered product
`timescale 1ns / 1ps
module wbc_mul (
   input  logic                              clock,
   input  wbc_pkg::mul_req_type              mul_req,
   output logic signed [wbc_pkg::PROD_W-1:0] prod_ff
);
   import wbc_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   // one product per enabled cycle
   assign prod_in = PROD_W'(mul_req.op_a) * PROD_W'(mul_req.op_b);

   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ----- sv/wheel_encoder_balance_correction.sv -----
// wheel_encoder_balance_correction: sequencer around one comparator and one multiplier
// sequence from request accept to rsp_valid: one compare per wheel pair, then per wheel a sum,
//   a gain multiply and factor update only if the wheel is not normal, the drive multiply and a store,
//   then the output register load, which waits while the previous result has not been taken
// a finished result waits in the output register while the next request is taken
// synchronous reset: factors to 1.0, previous direction to none, tolerance 15, gain 1049
`timescale 1ns / 1ps
module wheel_encoder_balance_correction (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  wbc_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output wbc_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wbc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [wbc_pkg::REG_W-1:0]             csr_data
);
   import wbc_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PAIR   = 3'd1;
   localparam logic [2:0] ST_SUM    = 3'd2;
   localparam logic [2:0] ST_MULG   = 3'd3;
   localparam logic [2:0] ST_FACT   = 3'd4;
   localparam logic [2:0] ST_MULS   = 3'd5;
   localparam logic [2:0] ST_STORE  = 3'd6;
   localparam logic [2:0] ST_FINISH = 3'd7;

   logic [2:0]               state_ff, state_in;
   logic [REG_W-1:0]         tolerance_ff;
   logic [REG_W-1:0]         gain_ff;
   logic [DIR_W-1:0]         dir_prev_ff;
   logic signed [CNT_W-1:0]  cnt_ff    [WHEEL_COUNT];
   logic signed [CNT_W-1:0]  drv_ff    [WHEEL_COUNT];
   logic signed [CNT_W-1:0]  out_ff    [WHEEL_COUNT];
   logic [FACTOR_W-1:0]      factor_ff [WHEEL_COUNT];
   logic [WHEEL_COUNT-1:0]   normal_ff;
   logic [PAIR_W-1:0]        pair_ff;
   logic [WHEEL_W-1:0]       wheel_ff;
   logic signed [SUM_W-1:0]  s_ff, s_in;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic                     req_fire;
   logic                     dir_change;
   logic                     agree;
   logic                     last_pair;
   logic                     last_wheel;
   logic                     out_free;
   mul_req_type              mul_req;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [CNT_W-1:0]  req_cnt [WHEEL_COUNT];
   logic signed [CNT_W-1:0]  req_drv [WHEEL_COUNT];

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign dir_change = req_data.drive_direction != dir_prev_ff;
   assign last_pair  = pair_ff == PAIR_W'(PAIR_COUNT - 1);
   assign last_wheel = wheel_ff == WHEEL_W'(WHEEL_COUNT - 1);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign req_cnt[0] = req_data.count_a;
   assign req_cnt[1] = req_data.count_b;
   assign req_cnt[2] = req_data.count_c;
   assign req_cnt[3] = req_data.count_d;
   assign req_drv[0] = req_data.drive_a;
   assign req_drv[1] = req_data.drive_b;
   assign req_drv[2] = req_data.drive_c;
   assign req_drv[3] = req_data.drive_d;

   // shared pair comparator
   wbc_agree u_agree (
      .cnt_x     (cnt_ff[PAIR_FIRST[pair_ff]]),
      .cnt_y     (cnt_ff[PAIR_SECOND[pair_ff]]),
      .tolerance (tolerance_ff),
      .agree     (agree)
   );

   // sum over normal wheels of their count minus this wheel's count
   always_comb begin
      s_in = '0;
      for (int j = 0; j < WHEEL_COUNT; j++) begin
         if (normal_ff[j]) begin
            s_in = s_in + SUM_W'(cnt_ff[j]) - SUM_W'(cnt_ff[wheel_ff]);
         end
      end
   end

   // multiplier operands: gain times sum, then drive times factor
   always_comb begin
      mul_req.en   = (state_ff == ST_MULG) || (state_ff == ST_MULS);
      mul_req.op_a = s_ff;
      mul_req.op_b = $signed({1'b0, gain_ff});
      if (state_ff == ST_MULS) begin
         mul_req.op_a = SUM_W'(drv_ff[wheel_ff]);
         mul_req.op_b = $signed({{(MUL_B_W-FACTOR_W){1'b0}}, factor_ff[wheel_ff]});
      end
   end

   wbc_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (prod_ff)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_PAIR;
         ST_PAIR:   if (last_pair) state_in = ST_SUM;
         ST_SUM:    state_in = normal_ff[wheel_ff] ? ST_MULS : ST_MULG;
         ST_MULG:   state_in = ST_FACT;
         ST_FACT:   state_in = ST_MULS;
         ST_MULS:   state_in = ST_STORE;
         ST_STORE:  state_in = last_wheel ? ST_FINISH : ST_SUM;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tolerance_ff <= TOLERANCE_RESET;
         gain_ff      <= GAIN_RESET;
         dir_prev_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         pair_ff      <= '0;
         wheel_ff     <= '0;
         normal_ff    <= '0;
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            factor_ff[i] <= FACTOR_ONE;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TOLERANCE) tolerance_ff <= csr_data;
            if (csr_index == CSR_GAIN)      gain_ff      <= csr_data;
         end
         // result taken, unless a new one replaces it this cycle
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  dir_prev_ff <= req_data.drive_direction;
                  pair_ff     <= '0;
                  wheel_ff    <= '0;
                  normal_ff   <= '0;
                  if (dir_change) begin
                     for (int i = 0; i < WHEEL_COUNT; i++) begin
                        factor_ff[i] <= FACTOR_ONE;
                     end
                  end
               end
            end
            ST_PAIR: begin
               if (agree) begin
                  normal_ff[PAIR_FIRST[pair_ff]]  <= 1'b1;
                  normal_ff[PAIR_SECOND[pair_ff]] <= 1'b1;
               end
               pair_ff <= pair_ff + 1'b1;
            end
            ST_FACT: begin
               factor_ff[wheel_ff] <= to_factor(prod_ff);
            end
            ST_STORE: begin
               wheel_ff <= wheel_ff + 1'b1;
            end
            ST_FINISH: begin
               if (out_free) rsp_valid_ff <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            cnt_ff[i] <= dir_change ? '0 : req_cnt[i];
            drv_ff[i] <= req_drv[i];
         end
      end
      if (state_ff == ST_SUM) begin
         s_ff <= s_in;
      end
      if (state_ff == ST_STORE) begin
         out_ff[wheel_ff] <= scale_pwm(prod_ff);
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_ff.out_a       <= out_ff[0];
         rsp_ff.out_b       <= out_ff[1];
         rsp_ff.out_c       <= out_ff[2];
         rsp_ff.out_d       <= out_ff[3];
         rsp_ff.normal_mask <= normal_ff;
      end
   end

endmodule

// ----- dv/wheel_encoder_balance_correction_tb.sv -----
// wheel_encoder_balance_correction_tb: self-checking bench with a balance predictor and random traffic
`timescale 1ns / 1ps
module wheel_encoder_balance_correction_tb;
   import wbc_pkg::*;

   // drive direction codes
   localparam logic [DIR_W-1:0] DIR_NONE  = DIR_W'(0);
   localparam logic [DIR_W-1:0] DIR_UP    = DIR_W'(1);
   localparam logic [DIR_W-1:0] DIR_DOWN  = DIR_W'(2);
   localparam logic [DIR_W-1:0] DIR_LEFT  = DIR_W'(3);
   localparam logic [DIR_W-1:0] DIR_RIGHT = DIR_W'(4);
   localparam logic [DIR_W-1:0] DIR_XTRA5 = DIR_W'(5);
   localparam logic [DIR_W-1:0] DIR_XTRA6 = DIR_W'(6);
   localparam logic [DIR_W-1:0] DIR_XTRA7 = DIR_W'(7);

   // first register index past the implemented ones
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_FIRST = CSR_GAIN + 1'b1;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 40;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [REG_W-1:0] csr_data;

   wheel_encoder_balance_correction dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // predictor state and shadow registers
   logic [FACTOR_W-1:0] factor_state [WHEEL_COUNT];
   logic [DIR_W-1:0]    last_dir;
   logic [REG_W-1:0]    tol_reg;
   logic [REG_W-1:0]    gain_reg;

   // bookkeeping
   req_type pending_reqs [$];
   rsp_type corrected_q [$];
   int      pushed_count = 0;
   int      accepted_count = 0;
   int      errors = 0;
   bit      req_taken = 0;
   bit      csr_taken = 0;
   int      req_gap = 0;
   int      rsp_stall = 0;
   int      hold_left = 0;
   bit      hold_request = 0;
   bit      no_idle = 0;

   // stimulus state
   logic [DIR_W-1:0] cur_dir = DIR_NONE;
   int               stim_tol = 15;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gap length: mostly short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle) begin
         return 0;
      end else if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(5, 60);
   endfunction

   // expected corrected pwm and mask for one request, advances predictor state
   function automatic rsp_type predict_correction(req_type rq);
      rsp_type                 r;
      int                      cnt [WHEEL_COUNT];
      logic signed [CNT_W-1:0] drv [WHEEL_COUNT];
      logic signed [CNT_W-1:0] pwm [WHEEL_COUNT];
      bit                      normal [WHEEL_COUNT];
      logic [WHEEL_COUNT-1:0]  mask;
      int                      d;
      longint                  s;
      longint                  acc;
      longint                  q;
      longint                  p;
      drv[0] = rq.drive_a;
      drv[1] = rq.drive_b;
      drv[2] = rq.drive_c;
      drv[3] = rq.drive_d;
      // direction change clears factors and zeroes counts
      if (rq.drive_direction != last_dir) begin
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            factor_state[i] = FACTOR_ONE;
            cnt[i] = 0;
         end
      end else begin
         cnt[0] = rq.count_a;
         cnt[1] = rq.count_b;
         cnt[2] = rq.count_c;
         cnt[3] = rq.count_d;
      end
      last_dir = rq.drive_direction;
      // agreement with any other wheel
      mask = '0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         normal[i] = 1'b0;
         for (int j = 0; j < WHEEL_COUNT; j++) begin
            d = cnt[i] - cnt[j];
            if (d < 0) begin
               d = -d;
            end
            if (i != j && d <= int'(tol_reg)) begin
               normal[i] = 1'b1;
            end
         end
         mask[i] = normal[i];
      end
      // new factor for outliers, then scale pwm
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         if (!normal[i]) begin
            s = 0;
            for (int j = 0; j < WHEEL_COUNT; j++) begin
               if (normal[j]) begin
                  s += longint'(cnt[j]) - longint'(cnt[i]);
               end
            end
            acc = 64'sd1048576 + longint'(gain_reg) * s;
            if (acc < 0) begin
               q = longint'(FACTOR_LO);
            end else begin
               q = acc / 64;
               if (q < longint'(FACTOR_LO)) begin
                  q = longint'(FACTOR_LO);
               end
               if (q > longint'(FACTOR_HI)) begin
                  q = longint'(FACTOR_HI);
               end
            end
            factor_state[i] = FACTOR_W'(q);
         end
         p = (longint'(drv[i]) * longint'(factor_state[i])) / 16384;
         if (p > 32767) begin
            p = 32767;
         end
         if (p < -32768) begin
            p = -32768;
         end
         pwm[i] = CNT_W'(p);
      end
      r.out_a = pwm[0];
      r.out_b = pwm[1];
      r.out_c = pwm[2];
      r.out_d = pwm[3];
      r.normal_mask = mask;
      return r;
   endfunction

   task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
                  $signed(want), $signed(got));
         errors++;
      end
   endtask

   // monitor: accepted requests, results and register writes
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         req_taken = 1'b0;
         csr_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         csr_taken = csr_valid && csr_ready;
         if (rsp_valid && rsp_ready) begin
            if (corrected_q.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h", $time, rsp_data);
               errors++;
            end else begin
               want = corrected_q.pop_front();
               check_field("out_a", want.out_a, rsp_data.out_a);
               check_field("out_b", want.out_b, rsp_data.out_b);
               check_field("out_c", want.out_c, rsp_data.out_c);
               check_field("out_d", want.out_d, rsp_data.out_d);
               check_field("normal_mask", CNT_W'(want.normal_mask),
                           CNT_W'(rsp_data.normal_mask));
            end
         end
         if (csr_taken) begin
            if (csr_index == CSR_TOLERANCE) begin
               tol_reg = csr_data;
            end else if (csr_index == CSR_GAIN) begin
               gain_reg = csr_data;
            end
         end
         if (req_taken) begin
            corrected_q.push_back(predict_correction(req_data));
            accepted_count++;
         end
      end
   end

   // request driver fed from the pending queue
   always @(negedge clock) begin : driver
      logic    nv;
      req_type nd;
      nv = req_valid;
      nd = req_data;
      if (!reset) begin
         if (req_valid && req_taken) begin
            nv = 1'b0;
         end
         if (!nv) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_reqs.size() > 0) begin
               nd = pending_reqs.pop_front();
               nv = 1'b1;
               req_gap = gap_len();
            end
         end
         req_valid <= nv;
         req_data  <= nd;
      end
   end

   // result receiver with random stalls and one long hold-off
   always @(negedge clock) begin : receiver
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_stall = gap_len();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic req_type mk_req(logic [DIR_W-1:0] dir, int ca, int cb, int cc, int cd,
                                      int da, int db, int dc, int dd);
      req_type rq;
      rq.drive_direction = dir;
      rq.count_a = CNT_W'(ca);
      rq.count_b = CNT_W'(cb);
      rq.count_c = CNT_W'(cc);
      rq.count_d = CNT_W'(cd);
      rq.drive_a = CNT_W'(da);
      rq.drive_b = CNT_W'(db);
      rq.drive_c = CNT_W'(dc);
      rq.drive_d = CNT_W'(dd);
      return rq;
   endfunction

   task automatic send(req_type rq);
      pending_reqs.push_back(rq);
      pushed_count++;
   endtask

   // pwm command: mostly random, sometimes an extreme or a value near zero
   function automatic int random_drive();
      if ($urandom_range(0, 3) != 0) begin
         return int'($signed(16'($urandom)));
      end
      case ($urandom_range(0, 4))
         0: return 32767;
         1: return -32768;
         2: return 0;
         3: return -1;
         default: return int'($urandom_range(0, 200)) - 100;
      endcase
   endfunction

   // random request: mostly a held direction with clustered counts and outliers
   function automatic req_type random_request();
      int c [WHEEL_COUNT];
      int base;
      int span;
      int off;
      int w;
      if ($urandom_range(0, 99) < 12) begin
         cur_dir = DIR_W'($urandom_range(0, 7));
      end
      base = int'($urandom_range(0, 56000)) - 28000;
      span = (stim_tol > 1000) ? 1000 : stim_tol;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            for (int i = 0; i < WHEEL_COUNT; i++) begin
               c[i] = base + int'($urandom_range(0, span));
            end
            for (int k = $urandom_range(0, 2); k > 0; k--) begin
               w = $urandom_range(0, WHEEL_COUNT - 1);
               off = stim_tol + 1 + int'($urandom_range(0, 3000));
               c[w] = $urandom_range(0, 1) ? base + off : base - off;
            end
         end
         6, 7: begin
            for (int i = 0; i < WHEEL_COUNT; i++) begin
               c[i] = int'($signed(16'($urandom)));
            end
         end
         8: begin
            for (int i = 0; i < WHEEL_COUNT; i++) begin
               c[i] = base;
            end
         end
         default: begin
            off = stim_tol + 1 + int'($urandom_range(0, 50));
            for (int i = 0; i < WHEEL_COUNT; i++) begin
               c[i] = base + i * off;
            end
         end
      endcase
      return mk_req(cur_dir, c[0], c[1], c[2], c[3],
                    random_drive(), random_drive(), random_drive(), random_drive());
   endfunction

   // block is idle once every request is in and every result is out
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pushed_count != accepted_count || corrected_q.size() != 0);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [REG_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do begin
         @(negedge clock);
      end while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(logic [REG_W-1:0] tol, logic [REG_W-1:0] gn, int n,
                            bit quiet, bit squeeze);
      wait_idle();
      write_csr(CSR_TOLERANCE, tol);
      write_csr(CSR_GAIN, gn);
      stim_tol = int'(tol);
      no_idle = quiet;
      if (squeeze) begin
         hold_request = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         send(random_request());
      end
   endtask

   // main sequence
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      tol_reg   = TOLERANCE_RESET;
      gain_reg  = GAIN_RESET;
      last_dir  = DIR_NONE;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         factor_state[i] = FACTOR_ONE;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, field extremes and each corner case
      send(mk_req(DIR_NONE, 0, 0, 0, 0, 32767, -32768, 0, -1));
      send(mk_req(DIR_NONE, 0, 10, 20, 1000, 1000, -1000, 12345, 32767));
      send(mk_req(DIR_NONE, -32768, 32767, -32768, 32767, -32768, 32767, -1, 1));
      // no wheel agrees with another
      send(mk_req(DIR_NONE, 0, 100, 200, 300, 32767, 32767, 32767, 32767));
      // outlier far below: factor clamps high, pwm saturates
      send(mk_req(DIR_NONE, 32767, 32767, 32767, -32768, 32767, 32767, -32768, 32767));
      send(mk_req(DIR_NONE, 32767, 32767, 32767, -32768, -5, 20000, 100, -32768));
      // outlier far above: negative sum, factor clamps low
      send(mk_req(DIR_NONE, -32768, -32768, -32768, 32767, 32767, -32768, 9999, -32768));
      send(mk_req(DIR_NONE, 0, 0, 5000, -5000, 30000, -30000, 30000, -30000));
      // direction change ignores counts
      send(mk_req(DIR_UP, 1234, -999, 32767, -32768, 32767, -32768, 16384, -16384));
      send(mk_req(DIR_UP, 500, 510, 520, 530, 111, -222, 333, -444));
      send(mk_req(DIR_UP, 0, 0, 0, -30000, 32767, 32767, 32767, 32767));
      send(mk_req(DIR_DOWN, 0, 0, 0, -30000, 32767, 32767, 32767, 32767));
      send(mk_req(DIR_LEFT, 7, 7, 7, 7, -1, -1, -1, -1));
      send(mk_req(DIR_RIGHT, -32768, 0, 0, 0, -32768, -32768, -32768, -32768));
      // codes beyond right are directions of their own
      send(mk_req(DIR_XTRA5, 1, 2, 3, 4, 5, 6, 7, 8));
      send(mk_req(DIR_XTRA6, 1, 2, 3, 4, 5, 6, 7, 8));
      send(mk_req(DIR_XTRA7, 1, 2, 3, 4, 5, 6, 7, 8));
      send(mk_req(DIR_XTRA7, 100, 100, -20000, 30000, 32767, -32768, 32767, -32768));
      // difference exactly at tolerance agrees, one past does not
      send(mk_req(DIR_XTRA7, 0, 15, -16, 1000, 20000, 20000, 20000, 20000));
      send(mk_req(DIR_XTRA7, 0, 16, 32, 48, 20000, 20000, 20000, 20000));
      send(mk_req(DIR_XTRA7, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
      send(mk_req(DIR_NONE, 5, 5, 5, 5, 1, 1, 1, 1));

      // random phases over several register settings
      run_phase(TOLERANCE_RESET, GAIN_RESET, 300, 1'b0, 1'b0);
      run_phase(16'd0, 16'd0, 150, 1'b0, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 150, 1'b0, 1'b0);
      run_phase(16'd100, 16'd5000, 200, 1'b1, 1'b1);
      wait_idle();
      // writes to unimplemented indexes must leave the registers alone
      write_csr(CSR_INDEX_W'($urandom_range(int'(CSR_UNUSED_FIRST), (1 << CSR_INDEX_W) - 1)),
                REG_W'($urandom));
      write_csr({CSR_INDEX_W{1'b1}}, 16'hFFFF);
      run_phase(REG_W'($urandom_range(0, 3000)), REG_W'($urandom), 200, 1'b0, 1'b0);
      run_phase(16'd3, 16'hFFFF, 150, 1'b0, 1'b0);
      run_phase(TOLERANCE_RESET, GAIN_RESET, 100, 1'b1, 1'b0);

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && corrected_q.size() == 0) begin
         $display("wheel_encoder_balance_correction_tb: done, clean");
      end else begin
         $display("wheel_encoder_balance_correction_tb: done, errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("wheel_encoder_balance_correction_tb: done, errors");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/wbc_pkg.sv
sv/wbc_agree.sv
sv/wbc_mul.sv
sv/wheel_encoder_balance_correction.sv
dv/wheel_encoder_balance_correction_tb.sv
